### rtl/absd_pkg.sv
// Shared types and constants for the archive byte stream decryptor.
// No dependencies; used by the channel interfaces and the top level.
package absd_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned MIX_W    = 7;
   localparam int unsigned IDXA_W   = 5;
   localparam int unsigned IDXB_W   = 4;
   localparam int unsigned KEY_W    = 32;
   localparam int unsigned DATA_W   = 32;
   localparam int unsigned ADDR_W   = 4;

   // register indexes on paddr[3:2]
   typedef enum logic [1:0] {
      REG_ENCRYPT_ENABLE = 2'd0,
      REG_PATH_KEY       = 2'd1,
      REG_SIZE_KEY       = 2'd2,
      REG_INIT_MIX       = 2'd3
   } reg_index_type;

   localparam logic [IDXA_W-1:0] START_INDEX_A = 5'd0;
   localparam logic [IDXB_W-1:0] START_INDEX_B = 4'd8;
   localparam logic [IDXA_W-1:0] INDEX_A_LAST  = 5'd15;
   localparam logic [IDXB_W-1:0] INDEX_B_LAST  = 4'd12;
   localparam logic [IDXB_W-1:0] INDEX_B_WRAP  = 4'd8;
   localparam logic [MIX_W-1:0]  MIX_STEP      = 7'd2;

   typedef struct packed {
      logic [MIX_W-1:0]  mix;
      logic [IDXA_W-1:0] index_a;
      logic [IDXB_W-1:0] index_b;
      logic              swap;
   } cipher_state_type;

   // Pick byte (idx mod 4) of a little-endian key word.
   function automatic logic [BYTE_W-1:0] key_byte(input logic [KEY_W-1:0] word,
                                                  input logic [1:0] idx);
      logic [BYTE_W-1:0] result;
      case (idx)
         2'd0:    result = word[7:0];
         2'd1:    result = word[15:8];
         2'd2:    result = word[23:16];
         default: result = word[31:24];
      endcase
      return result;
   endfunction

   // Remainder by 7: octal digits sum since 8 is 1 mod 7.
   function automatic logic [2:0] mod7(input logic [MIX_W-1:0] m);
      logic [3:0] s1;
      logic [3:0] s2;
      logic [3:0] r;
      s1 = {3'd0, m[6]} + {1'b0, m[5:3]} + {1'b0, m[2:0]};
      s2 = {3'd0, s1[3]} + {1'b0, s1[2:0]};
      r  = (s2 >= 4'd7) ? (s2 - 4'd7) : s2;
      return r[2:0];
   endfunction

   // Remainder by 12: low two bits stay, upper five bits reduced mod 3.
   function automatic logic [3:0] mod12(input logic [MIX_W-1:0] m);
      logic [4:0] q;
      logic [2:0] s1;
      logic [2:0] s2;
      logic [2:0] r;
      q  = m[6:2];
      s1 = {2'd0, q[4]} + {1'b0, q[3:2]} + {1'b0, q[1:0]};
      s2 = {2'd0, s1[2]} + {1'b0, s1[1:0]};
      r  = (s2 >= 3'd3) ? (s2 - 3'd3) : s2;
      return {r[1:0], m[1:0]};
   endfunction

endpackage

### rtl/absd_req_if.sv
// Input channel carrying one cipher byte and a restart flag per transaction.
// Depends on absd_pkg for widths.
interface absd_req_if;
   logic                         valid;
   logic                         ready;
   logic [absd_pkg::BYTE_W-1:0]  cipher_byte;
   logic                         restart;

   modport source (output valid, output cipher_byte, output restart, input ready);
   modport sink   (input valid, input cipher_byte, input restart, output ready);
endinterface

### rtl/absd_rsp_if.sv
// Result channel carrying one plain byte per transaction.
// Depends on absd_pkg for widths.
interface absd_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [absd_pkg::BYTE_W-1:0]  plain_byte;

   modport source (output valid, output plain_byte, input ready);
   modport sink   (input valid, input plain_byte, output ready);
endinterface

### rtl/archive_byte_stream_decrypt.sv
// Archive byte stream decryptor: key state, cipher datapath and APB register file.
// Depends on absd_pkg, absd_req_if and absd_rsp_if.
//
// Takes one byte per clock unless the result register is held by a stalled sink,
// and returns one byte per transaction, in order, in the cycle after acceptance.
// The key state (mix value, two table indices and a nibble-swap flag) is
// updated in the same cycle a byte is taken; the only limit is the result
// register, which holds while the sink stalls and frees the input the cycle
// it is taken. A set restart flag reloads the start state (mix = init_mix,
// index A = 0, index B = 8, no swap) before that byte, as at file offset
// zero. With encrypt_enable clear, bytes pass unchanged and the key state
// holds except on restart. Registers: 0 encrypt_enable, 1 path_key,
// 2 size_key, 3 init_mix at byte addresses 0, 4, 8, 12; write them only while idle.
// A new init_mix takes effect at the next restart.
module archive_byte_stream_decrypt (
   input  logic                          clock,
   input  logic                          reset,
   absd_req_if.sink                      req,
   absd_rsp_if.source                    rsp,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [absd_pkg::ADDR_W-1:0]   paddr,
   input  logic [absd_pkg::DATA_W-1:0]   pwdata,
   output logic [absd_pkg::DATA_W-1:0]   prdata,
   output logic                          pready
);

   // ---------------------------------------------------------------
   // Register file
   // ---------------------------------------------------------------
   logic                            enable_ff;
   logic [absd_pkg::KEY_W-1:0]      path_key_ff;
   logic [absd_pkg::KEY_W-1:0]      size_key_ff;
   logic [absd_pkg::MIX_W-1:0]      init_mix_ff;
   logic                            csr_write;
   absd_pkg::reg_index_type         csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite;
   assign csr_index = absd_pkg::reg_index_type'(paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff   <= 1'b0;
         path_key_ff <= '0;
         size_key_ff <= '0;
         init_mix_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            absd_pkg::REG_ENCRYPT_ENABLE: enable_ff   <= pwdata[0];
            absd_pkg::REG_PATH_KEY:       path_key_ff <= pwdata;
            absd_pkg::REG_SIZE_KEY:       size_key_ff <= pwdata;
            absd_pkg::REG_INIT_MIX:       init_mix_ff <= pwdata[absd_pkg::MIX_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         absd_pkg::REG_ENCRYPT_ENABLE: prdata = {31'd0, enable_ff};
         absd_pkg::REG_PATH_KEY:       prdata = path_key_ff;
         absd_pkg::REG_SIZE_KEY:       prdata = size_key_ff;
         absd_pkg::REG_INIT_MIX:       prdata = {25'd0, init_mix_ff};
         default:                      prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------
   // Handshake: the result register frees the input when empty or taken
   // ---------------------------------------------------------------
   logic                            rsp_valid_ff;
   logic                            rsp_valid_in;
   logic [absd_pkg::BYTE_W-1:0]     plain_ff;
   logic [absd_pkg::BYTE_W-1:0]     plain_in;
   logic                            accept;

   assign req.ready = ~rsp_valid_ff | rsp.ready;
   assign accept    = req.valid & req.ready;

   // ---------------------------------------------------------------
   // Key state and datapath
   // ---------------------------------------------------------------
   absd_pkg::cipher_state_type      state_ff;
   absd_pkg::cipher_state_type      state_in;
   absd_pkg::cipher_state_type      cur;     // state after an optional restart
   absd_pkg::cipher_state_type      nxt;     // state after advancing
   logic [absd_pkg::BYTE_W-1:0]     stage1;
   logic [absd_pkg::BYTE_W-1:0]     stage2;
   logic [absd_pkg::IDXA_W-1:0]     a_inc;
   logic [absd_pkg::IDXB_W-1:0]     b_inc;
   logic [absd_pkg::MIX_W-1:0]      mix_adv;
   logic [2:0]                      mix_m7;
   logic [3:0]                      mix_m12;

   always_comb begin
      // Reload the start state ahead of this byte on restart
      if (req.restart) begin
         cur.mix     = init_mix_ff;
         cur.index_a = absd_pkg::START_INDEX_A;
         cur.index_b = absd_pkg::START_INDEX_B;
         cur.swap    = 1'b0;
      end else begin
         cur = state_ff;
      end

      stage1 = req.cipher_byte ^ {1'b0, cur.mix}
             ^ absd_pkg::key_byte(size_key_ff, cur.index_b[1:0]);
      stage2 = cur.swap ? {stage1[3:0], stage1[7:4]} : stage1;

      if (enable_ff) begin
         plain_in = stage2 ^ absd_pkg::key_byte(path_key_ff, cur.index_a[1:0]);
      end else begin
         plain_in = req.cipher_byte;
      end

      // Advance indices; wrap, toggle swap or re-seed from the mix
      a_inc   = cur.index_a + 5'd1;
      b_inc   = cur.index_b + 4'd1;
      mix_adv = cur.mix + absd_pkg::MIX_STEP;
      mix_m7  = absd_pkg::mod7(mix_adv);
      mix_m12 = absd_pkg::mod12(mix_adv);
      nxt     = cur;
      nxt.index_a = a_inc;
      nxt.index_b = b_inc;
      if (a_inc <= absd_pkg::INDEX_A_LAST) begin
         if (b_inc > absd_pkg::INDEX_B_LAST) begin
            nxt.index_b = '0;
            nxt.swap    = ~cur.swap;
         end
      end else if (b_inc <= absd_pkg::INDEX_B_WRAP) begin
         nxt.index_a = '0;
         nxt.swap    = ~cur.swap;
      end else begin
         nxt.mix = mix_adv;
         if (cur.swap) begin
            nxt.swap    = 1'b0;
            nxt.index_a = {2'd0, mix_m7};
            nxt.index_b = mix_m12 + 4'd2;
         end else begin
            nxt.swap    = 1'b1;
            nxt.index_a = {1'b0, mix_m12} + 5'd3;
            nxt.index_b = {1'b0, mix_m7};
         end
      end

      // Hold the key state when idle; when bypassed, only a restart changes it
      if (accept) begin
         state_in = enable_ff ? nxt : cur;
      end else begin
         state_in = state_ff;
      end

      rsp_valid_in = accept | (rsp_valid_ff & ~rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mix     <= '0;
         state_ff.index_a <= absd_pkg::START_INDEX_A;
         state_ff.index_b <= absd_pkg::START_INDEX_B;
         state_ff.swap    <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         plain_ff <= plain_in;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.plain_byte = plain_ff;

endmodule
